>>> rtl/core/fzag_pkg.sv
// ============================================================================
// fzag_pkg
// Shared types and constants for the fractal-Z layout address generator.
// ============================================================================
package fzag_pkg;

  // Kernel dimension is always padded to a multiple of this block size.
  localparam int unsigned KERNEL_BLOCK = 16;

  // Widths fixed by the register and payload fields.
  localparam int unsigned LAYOUT_W   = 2;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned SPATIAL_W  = 5;
  localparam int unsigned N1N0_W     = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DEST_W     = 33;
  localparam int unsigned SRC_W      = 32;

  // Largest values the register fields can carry.
  localparam int unsigned COUNT_FIELD_MAX   = (1 << COUNT_W) - 1;
  localparam int unsigned SPATIAL_FIELD_MAX = (1 << SPATIAL_W) - 1;

  // Source tensor orders.
  localparam logic [LAYOUT_W-1:0] LAYOUT_NCHW = 2'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_HWCN = 2'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_NHWC = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LAYOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_WIDE     = 3'd5;

  // Cycles the stride pipeline needs after a register write or reset.
  localparam logic [1:0] STRIDE_SETTLE = 2'd2;

  // Effective tensor geometry, sizes already clamped.
  typedef struct packed {
    logic [LAYOUT_W-1:0]  layout;
    logic [COUNT_W-1:0]   n;
    logic [COUNT_W-1:0]   c;
    logic [SPATIAL_W-1:0] h;
    logic [SPATIAL_W-1:0] w;
    logic                 wide;
    logic [N1N0_W-1:0]    n1n0;
  } geom_t;

  // Source index step for one unit along each tensor dimension.
  typedef struct packed {
    logic [SRC_W-1:0] sn;
    logic [SRC_W-1:0] sc;
    logic [SRC_W-1:0] sh;
    logic [SRC_W-1:0] sw;
  } stride_t;

  // One result item.
  typedef struct packed {
    logic [DEST_W-1:0] dest_index;
    logic [SRC_W-1:0]  source_index;
    logic              zero_fill;
    logic              last_element;
  } res_t;

  // Clamp a size field into the range one to hi.
  function automatic logic [COUNT_W-1:0] clamp_size(input logic [COUNT_W-1:0] v,
                                                    input int unsigned hi);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (32'(v) > hi) begin
      r = COUNT_W'(hi);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fzag_cfg_strides.sv
// ============================================================================
// fzag_cfg_strides
// Configuration registers, size clamping and the two-stage stride pipeline.
// ============================================================================
module fzag_cfg_strides #(
  parameter int unsigned MAX_KERNELS  = 4096,
  parameter int unsigned MAX_CHANNELS = 4096,
  parameter int unsigned MAX_SPATIAL  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fzag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fzag_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fzag_pkg::geom_t                   geom_o,
  output fzag_pkg::stride_t                 strides_o,
  output logic                              busy_o
);

  // Raw register contents.
  logic [fzag_pkg::LAYOUT_W-1:0]  layout_r;
  logic [fzag_pkg::COUNT_W-1:0]   kcount_r;
  logic [fzag_pkg::COUNT_W-1:0]   ccount_r;
  logic [fzag_pkg::SPATIAL_W-1:0] height_r;
  logic [fzag_pkg::SPATIAL_W-1:0] width_r;
  logic                           wide_r;

  fzag_pkg::geom_t   geom_nxt;
  fzag_pkg::geom_t   geom_r;
  fzag_pkg::stride_t strides_nxt;
  fzag_pkg::stride_t strides_r;

  logic [9:0]  hw_nxt, hw_r;
  logic [25:0] cn_nxt, cn_r;
  logic [17:0] wc_nxt, wc_r;
  logic [22:0] chw;
  logic [30:0] wcn;
  logic [22:0] hwc;
  logic [fzag_pkg::COUNT_W-1:0] n_cl;
  logic [fzag_pkg::COUNT_W-1:0] c_cl;
  logic [fzag_pkg::COUNT_W-1:0] h_cl;
  logic [fzag_pkg::COUNT_W-1:0] w_cl;
  logic [1:0]  settle_r;

  // Register writes; reset gives the documented defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= fzag_pkg::LAYOUT_NCHW;
      kcount_r <= fzag_pkg::COUNT_W'(1);
      ccount_r <= fzag_pkg::COUNT_W'(1);
      height_r <= fzag_pkg::SPATIAL_W'(1);
      width_r  <= fzag_pkg::SPATIAL_W'(1);
      wide_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fzag_pkg::REG_SOURCE_LAYOUT: layout_r <= cfg_data[fzag_pkg::LAYOUT_W-1:0];
        fzag_pkg::REG_KERNEL_COUNT:  kcount_r <= cfg_data[fzag_pkg::COUNT_W-1:0];
        fzag_pkg::REG_CHANNEL_COUNT: ccount_r <= cfg_data[fzag_pkg::COUNT_W-1:0];
        fzag_pkg::REG_KERNEL_HEIGHT: height_r <= cfg_data[fzag_pkg::SPATIAL_W-1:0];
        fzag_pkg::REG_KERNEL_WIDTH:  width_r  <= cfg_data[fzag_pkg::SPATIAL_W-1:0];
        fzag_pkg::REG_CUBE_WIDE:     wide_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Clamp sizes and round the kernel count up to a whole block.
  always_comb begin
    n_cl = fzag_pkg::clamp_size(kcount_r, MAX_KERNELS);
    c_cl = fzag_pkg::clamp_size(ccount_r, MAX_CHANNELS);
    h_cl = fzag_pkg::clamp_size(fzag_pkg::COUNT_W'(height_r), MAX_SPATIAL);
    w_cl = fzag_pkg::clamp_size(fzag_pkg::COUNT_W'(width_r), MAX_SPATIAL);
    geom_nxt.layout = (layout_r inside {fzag_pkg::LAYOUT_HWCN, fzag_pkg::LAYOUT_NHWC}) ?
                      layout_r : fzag_pkg::LAYOUT_NCHW;
    geom_nxt.n    = n_cl;
    geom_nxt.c    = c_cl;
    geom_nxt.h    = h_cl[fzag_pkg::SPATIAL_W-1:0];
    geom_nxt.w    = w_cl[fzag_pkg::SPATIAL_W-1:0];
    geom_nxt.wide = wide_r;
    geom_nxt.n1n0 = (fzag_pkg::N1N0_W'(n_cl) + fzag_pkg::N1N0_W'(fzag_pkg::KERNEL_BLOCK - 1))
                    & ~fzag_pkg::N1N0_W'(fzag_pkg::KERNEL_BLOCK - 1);
    hw_nxt = 10'(geom_nxt.h) * 10'(geom_nxt.w);
    cn_nxt = 26'(geom_nxt.c) * 26'(geom_nxt.n);
    wc_nxt = 18'(geom_nxt.w) * 18'(geom_nxt.c);
  end

  // First stage: geometry and the pairwise products.
  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
    hw_r   <= hw_nxt;
    cn_r   <= cn_nxt;
    wc_r   <= wc_nxt;
  end

  // Second stage: triple products and the stride set for the layout.
  always_comb begin
    chw = 23'(geom_r.c) * 23'(hw_r);
    wcn = 31'(geom_r.w) * 31'(cn_r);
    hwc = 23'(geom_r.h) * 23'(wc_r);
    case (geom_r.layout)
      fzag_pkg::LAYOUT_HWCN: begin
        strides_nxt.sn = 32'd1;
        strides_nxt.sc = 32'(geom_r.n);
        strides_nxt.sh = 32'(wcn);
        strides_nxt.sw = 32'(cn_r);
      end
      fzag_pkg::LAYOUT_NHWC: begin
        strides_nxt.sn = 32'(hwc);
        strides_nxt.sc = 32'd1;
        strides_nxt.sh = 32'(wc_r);
        strides_nxt.sw = 32'(geom_r.c);
      end
      default: begin
        strides_nxt.sn = 32'(chw);
        strides_nxt.sc = 32'(hw_r);
        strides_nxt.sh = 32'(geom_r.w);
        strides_nxt.sw = 32'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    strides_r <= strides_nxt;
  end

  // Hold off new items until the stride pipeline has caught up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= fzag_pkg::STRIDE_SETTLE;
    end else if (cfg_we) begin
      settle_r <= fzag_pkg::STRIDE_SETTLE;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  assign geom_o    = geom_r;
  assign strides_o = strides_r;
  assign busy_o    = (settle_r != 2'd0);

endmodule

>>> rtl/core/fzag_walk.sv
// ============================================================================
// fzag_walk
// Nested walk counters with incremental source offsets; forms one result.
// ============================================================================
module fzag_walk #(
  parameter int unsigned MAX_KERNELS  = 4096,
  parameter int unsigned MAX_CHANNELS = 4096,
  parameter int unsigned MAX_SPATIAL  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              restart,
  input  logic              cfg_we,
  input  fzag_pkg::geom_t   geom,
  input  fzag_pkg::stride_t strides,
  output fzag_pkg::res_t    res_o
);

  localparam int unsigned KLIM = (MAX_KERNELS < fzag_pkg::COUNT_FIELD_MAX) ?
                                 MAX_KERNELS : fzag_pkg::COUNT_FIELD_MAX;
  localparam int unsigned CLIM = (MAX_CHANNELS < fzag_pkg::COUNT_FIELD_MAX) ?
                                 MAX_CHANNELS : fzag_pkg::COUNT_FIELD_MAX;
  localparam int unsigned SLIM = (MAX_SPATIAL < fzag_pkg::SPATIAL_FIELD_MAX) ?
                                 MAX_SPATIAL : fzag_pkg::SPATIAL_FIELD_MAX;
  localparam int unsigned N1N0_MAX = ((KLIM + fzag_pkg::KERNEL_BLOCK - 1) /
                                      fzag_pkg::KERNEL_BLOCK) * fzag_pkg::KERNEL_BLOCK;
  localparam int unsigned KCW = $clog2(N1N0_MAX);
  localparam int unsigned SCW = (SLIM > 1) ? $clog2(SLIM) : 1;
  localparam int unsigned CIW = $clog2(CLIM + 32);

  // Walk position.
  logic [4:0]                    lane_r,  lane_nxt,  cur_lane;
  logic [KCW-1:0]                kern_r,  kern_nxt,  cur_kern;
  logic [SCW-1:0]                col_r,   col_nxt,   cur_col;
  logic [SCW-1:0]                row_r,   row_nxt,   cur_row;
  logic [CIW-1:0]                cib_r,   cib_nxt,   cur_cib;
  logic [fzag_pkg::DEST_W-1:0]   dest_r,  dest_nxt,  cur_dest;
  // Source offsets contributed by each counter.
  logic [fzag_pkg::SRC_W-1:0]    offn_r,  offn_nxt,  cur_offn;
  logic [fzag_pkg::SRC_W-1:0]    offl_r,  offl_nxt,  cur_offl;
  logic [fzag_pkg::SRC_W-1:0]    offb_r,  offb_nxt,  cur_offb;
  logic [fzag_pkg::SRC_W-1:0]    offh_r,  offh_nxt,  cur_offh;
  logic [fzag_pkg::SRC_W-1:0]    offw_r,  offw_nxt,  cur_offw;

  logic [5:0]                    c0;
  logic [CIW-1:0]                ci;
  logic [fzag_pkg::SRC_W-1:0]    blk_stride;
  logic [fzag_pkg::SRC_W-1:0]    src_sum;
  logic pad, last_lane, last_kern, last_col, last_row, last_blk, last;

  // Current position, with a requested restart taking it back to zero.
  always_comb begin
    cur_lane = restart ? '0 : lane_r;
    cur_kern = restart ? '0 : kern_r;
    cur_col  = restart ? '0 : col_r;
    cur_row  = restart ? '0 : row_r;
    cur_cib  = restart ? '0 : cib_r;
    cur_dest = restart ? '0 : dest_r;
    cur_offn = restart ? '0 : offn_r;
    cur_offl = restart ? '0 : offl_r;
    cur_offb = restart ? '0 : offb_r;
    cur_offh = restart ? '0 : offh_r;
    cur_offw = restart ? '0 : offw_r;
  end

  // Padding test, end-of-dimension flags and the source index.
  always_comb begin
    c0         = geom.wide ? 6'd32 : 6'd16;
    blk_stride = geom.wide ? (strides.sc << 5) : (strides.sc << 4);
    ci         = cur_cib + CIW'(cur_lane);
    pad        = (32'(ci) >= 32'(geom.c)) || (32'(cur_kern) >= 32'(geom.n));
    last_lane  = (6'(cur_lane) + 6'd1) >= c0;
    last_kern  = (32'(cur_kern) + 32'd1) >= 32'(geom.n1n0);
    last_col   = (32'(cur_col) + 32'd1) >= 32'(geom.w);
    last_row   = (32'(cur_row) + 32'd1) >= 32'(geom.h);
    last_blk   = (32'(cur_cib) + 32'(c0)) >= 32'(geom.c);
    last       = last_lane && last_kern && last_col && last_row && last_blk;
    src_sum    = cur_offn + cur_offb + cur_offl + cur_offh + cur_offw;

    res_o.dest_index   = cur_dest;
    res_o.source_index = pad ? '0 : src_sum;
    res_o.zero_fill    = pad;
    res_o.last_element = last;
  end

  // Advance the innermost counter that has not reached its end.
  always_comb begin
    lane_nxt = '0;
    kern_nxt = cur_kern;
    col_nxt  = cur_col;
    row_nxt  = cur_row;
    cib_nxt  = cur_cib;
    offl_nxt = '0;
    offn_nxt = cur_offn;
    offw_nxt = cur_offw;
    offh_nxt = cur_offh;
    offb_nxt = cur_offb;
    dest_nxt = cur_dest + fzag_pkg::DEST_W'(1);
    if (last) begin
      kern_nxt = '0;
      col_nxt  = '0;
      row_nxt  = '0;
      cib_nxt  = '0;
      offn_nxt = '0;
      offw_nxt = '0;
      offh_nxt = '0;
      offb_nxt = '0;
      dest_nxt = '0;
    end else if (!last_lane) begin
      lane_nxt = cur_lane + 5'd1;
      offl_nxt = cur_offl + strides.sc;
    end else if (!last_kern) begin
      kern_nxt = cur_kern + KCW'(1);
      offn_nxt = cur_offn + strides.sn;
    end else if (!last_col) begin
      kern_nxt = '0;
      offn_nxt = '0;
      col_nxt  = cur_col + SCW'(1);
      offw_nxt = cur_offw + strides.sw;
    end else if (!last_row) begin
      kern_nxt = '0;
      offn_nxt = '0;
      col_nxt  = '0;
      offw_nxt = '0;
      row_nxt  = cur_row + SCW'(1);
      offh_nxt = cur_offh + strides.sh;
    end else begin
      kern_nxt = '0;
      offn_nxt = '0;
      col_nxt  = '0;
      offw_nxt = '0;
      row_nxt  = '0;
      offh_nxt = '0;
      cib_nxt  = cur_cib + CIW'(c0);
      offb_nxt = cur_offb + blk_stride;
    end
  end

  // Position registers; a register write also restarts the walk.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      lane_r <= '0;
      kern_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
      cib_r  <= '0;
      dest_r <= '0;
      offn_r <= '0;
      offl_r <= '0;
      offb_r <= '0;
      offh_r <= '0;
      offw_r <= '0;
    end else if (step) begin
      lane_r <= lane_nxt;
      kern_r <= kern_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cib_r  <= cib_nxt;
      dest_r <= dest_nxt;
      offn_r <= offn_nxt;
      offl_r <= offl_nxt;
      offb_r <= offb_nxt;
      offh_r <= offh_nxt;
      offw_r <= offw_nxt;
    end
  end

endmodule

>>> rtl/core/fzag_out_buf.sv
// ============================================================================
// fzag_out_buf
// Result register with a skid entry, so the stall into the walk is registered.
// ============================================================================
module fzag_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fzag_pkg::res_t push_data,
  output logic           full_o,
  output logic           out_valid,
  input  logic           out_stall,
  output fzag_pkg::res_t out_data
);

  logic           main_vld_r, main_vld_nxt;
  logic           skid_vld_r, skid_vld_nxt;
  fzag_pkg::res_t main_r, main_nxt;
  fzag_pkg::res_t skid_r, skid_nxt;
  logic           take;

  // Refill the result register from the skid entry first, then from the walk.
  always_comb begin
    take         = main_vld_r && !out_stall;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (take) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = push_data;
      end else begin
        main_vld_nxt = push;
        main_nxt     = push_data;
      end
    end else if (!main_vld_r) begin
      main_vld_nxt = push;
      main_nxt     = push_data;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full_o    = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

>>> rtl/core/fractal_z_layout_address_gen_unit.sv
// ============================================================================
// fractal_z_layout_address_gen_unit
// Address generator for rearranging convolution weights into fractal-Z order.
// ============================================================================
// Each transfer on the in_ channel asks for one destination element; the walk
// runs in (C1, H, W, N rounded to 16, C0) order and in_restart sends it back
// to element zero first. Each transfer on the out_ channel carries the
// destination index, the source index for the programmed layout (NCHW, HWCN
// or NHWC), a pad flag for channels or kernels past the tensor, and a flag
// on the final element, after which the walk wraps round on its own.
// The result of an input transfer is registered before out_valid shows it;
// one item is taken every cycle while in_stall is low: the walk counters
// step with running source offsets, so only one five-term add sits before
// the result register. A result register with a skid entry lets one more
// item in while out_stall is high; in_stall rises once both are full.
// Registers are written on the cfg_ channel; any write restarts the walk and
// re-runs the stride pipeline, during which in_stall is held high. After
// reset the first input transfer likewise waits for the stride pipeline,
// with the walk at element zero and the registers at their defaults.
// ============================================================================
module fractal_z_layout_address_gen_unit #(
  parameter int unsigned MAX_KERNELS  = 4096,
  parameter int unsigned MAX_CHANNELS = 4096,
  parameter int unsigned MAX_SPATIAL  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_restart,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fzag_pkg::DEST_W-1:0]      out_dest_index,
  output logic [fzag_pkg::SRC_W-1:0]       out_source_index,
  output logic                             out_zero_fill,
  output logic                             out_last_element,
  // Configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fzag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fzag_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fzag_pkg::geom_t   geom;
  fzag_pkg::stride_t strides;
  fzag_pkg::res_t    walk_res;
  fzag_pkg::res_t    out_res;
  logic              busy;
  logic              full;
  logic              cfg_we;
  logic              in_take;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign in_stall = busy || full;
  assign in_take  = in_valid && !in_stall;

  fzag_cfg_strides #(
    .MAX_KERNELS  (MAX_KERNELS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SPATIAL  (MAX_SPATIAL)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom_o    (geom),
    .strides_o (strides),
    .busy_o    (busy)
  );

  fzag_walk #(
    .MAX_KERNELS  (MAX_KERNELS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SPATIAL  (MAX_SPATIAL)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_take),
    .restart (in_restart),
    .cfg_we  (cfg_we),
    .geom    (geom),
    .strides (strides),
    .res_o   (walk_res)
  );

  fzag_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (walk_res),
    .full_o    (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // Result fields onto their ports.
  assign out_dest_index   = out_res.dest_index;
  assign out_source_index = out_res.source_index;
  assign out_zero_fill    = out_res.zero_fill;
  assign out_last_element = out_res.last_element;

endmodule

>>> verif/fractal_z_layout_address_gen_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// fractal_z_layout_address_gen_unit_tb
// Self-checking bench for the fractal-Z weight layout address generator.
// ============================================================================
// A driver offers walk requests from a queue, and a monitor checks every
// result transfer against an address predictor written for this bench.
// Register settings change only while the block is idle. They cover all the
// source layouts and the reserved code, zero and oversized sizes, and writes
// to unused register indexes. Between those settings come walks short enough
// to wrap, with random restarts. Random idle bursts fall on both channels.
// Up to two long receiver hold-offs fill the block. The last phase runs
// with no idling at all.
// ============================================================================
module fractal_z_layout_address_gen_unit_tb;

  localparam int unsigned MAX_KERNELS  = 4096;
  localparam int unsigned MAX_CHANNELS = 4096;
  localparam int unsigned MAX_SPATIAL  = 16;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned QUIET_ITEMS  = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 48;
  localparam int unsigned HOLD_DEPTH   = 64;
  localparam int unsigned MAX_REPORTS  = 100;

  // Codes outside the documented register map.
  localparam logic [fzag_pkg::LAYOUT_W-1:0]  LAYOUT_RESERVED = 2'd3;
  localparam logic [fzag_pkg::CFG_IDX_W-1:0] REG_SPARE_LO    = 3'd6;
  localparam logic [fzag_pkg::CFG_IDX_W-1:0] REG_SPARE_HI    = 3'd7;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic                            in_restart = 1'b0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic [fzag_pkg::DEST_W-1:0]     out_dest_index;
  logic [fzag_pkg::SRC_W-1:0]      out_source_index;
  logic                            out_zero_fill;
  logic                            out_last_element;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [fzag_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [fzag_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  // Predictor copy of the registers and the walk position.
  logic [fzag_pkg::LAYOUT_W-1:0]  cur_layout;
  logic [fzag_pkg::COUNT_W-1:0]   cur_kernels;
  logic [fzag_pkg::COUNT_W-1:0]   cur_channels;
  logic [fzag_pkg::SPATIAL_W-1:0] cur_height;
  logic [fzag_pkg::SPATIAL_W-1:0] cur_width;
  logic                           cur_wide;
  int unsigned                    blk_pos, row_pos, col_pos, kern_pos, lane_pos;
  logic [fzag_pkg::DEST_W-1:0]    dest_next;

  bit             pending_restarts[$];
  fzag_pkg::res_t expected_addrs[$];
  fzag_pkg::res_t want;

  int unsigned n_errors     = 0;
  int unsigned n_reports    = 0;
  int unsigned n_sent       = 0;
  int unsigned n_checked    = 0;
  int unsigned n_last_seen  = 0;
  int unsigned n_pad_seen   = 0;
  int unsigned n_restarts   = 0;
  int unsigned n_settings   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_done   = 0;
  int unsigned cycles       = 0;
  bit          quiet        = 1'b0;
  bit          hold_wanted  = 1'b0;

  fractal_z_layout_address_gen_unit #(
    .MAX_KERNELS (MAX_KERNELS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_SPATIAL (MAX_SPATIAL)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dest_index  (out_dest_index),
    .out_source_index(out_source_index),
    .out_zero_fill   (out_zero_fill),
    .out_last_element(out_last_element),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sizes of zero count as one; anything past the maximum saturates.
  function automatic longint unsigned eff_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void reset_walk();
    blk_pos   = 0;
    row_pos   = 0;
    col_pos   = 0;
    kern_pos  = 0;
    lane_pos  = 0;
    dest_next = '0;
  endfunction

  // Any register write, even to an unused index, sends the walk back to zero.
  function automatic void apply_reg(logic [fzag_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fzag_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      fzag_pkg::REG_SOURCE_LAYOUT: cur_layout   = data[fzag_pkg::LAYOUT_W-1:0];
      fzag_pkg::REG_KERNEL_COUNT:  cur_kernels  = data[fzag_pkg::COUNT_W-1:0];
      fzag_pkg::REG_CHANNEL_COUNT: cur_channels = data[fzag_pkg::COUNT_W-1:0];
      fzag_pkg::REG_KERNEL_HEIGHT: cur_height   = data[fzag_pkg::SPATIAL_W-1:0];
      fzag_pkg::REG_KERNEL_WIDTH:  cur_width    = data[fzag_pkg::SPATIAL_W-1:0];
      fzag_pkg::REG_CUBE_WIDE:     cur_wide     = data[0];
      default: ;
    endcase
    reset_walk();
  endfunction

  // Works out the addresses of the current element and steps the walk on.
  function automatic fzag_pkg::res_t next_address(bit restart);
    longint unsigned n, c, h, w, c0, c1, n1n0, ci, ni, src;
    bit   pad, end_lane, end_kern, end_col, end_row, end_blk, at_end;
    fzag_pkg::res_t r;
    n    = eff_size(cur_kernels, MAX_KERNELS);
    c    = eff_size(cur_channels, MAX_CHANNELS);
    h    = eff_size(cur_height, MAX_SPATIAL);
    w    = eff_size(cur_width, MAX_SPATIAL);
    c0   = cur_wide ? 32 : 16;
    c1   = (c + c0 - 1) / c0;
    n1n0 = ((n + fzag_pkg::KERNEL_BLOCK - 1) / fzag_pkg::KERNEL_BLOCK) * fzag_pkg::KERNEL_BLOCK;
    if (restart) begin
      reset_walk();
    end
    ci  = blk_pos * c0 + lane_pos;
    ni  = kern_pos;
    pad = (ci >= c) || (ni >= n);
    src = 0;
    if (!pad) begin
      case (cur_layout)
        fzag_pkg::LAYOUT_HWCN: src = ((row_pos * w + col_pos) * c + ci) * n + ni;
        fzag_pkg::LAYOUT_NHWC: src = ((ni * h + row_pos) * w + col_pos) * c + ci;
        default:               src = ((ni * c + ci) * h + row_pos) * w + col_pos;
      endcase
    end
    end_lane = lane_pos + 1 >= c0;
    end_kern = kern_pos + 1 >= n1n0;
    end_col  = col_pos + 1 >= w;
    end_row  = row_pos + 1 >= h;
    end_blk  = blk_pos + 1 >= c1;
    at_end   = end_lane && end_kern && end_col && end_row && end_blk;

    r.dest_index   = dest_next;
    r.source_index = src[fzag_pkg::SRC_W-1:0];
    r.zero_fill    = pad;
    r.last_element = at_end;

    // Innermost counter first; each one carries into the next when it wraps.
    if (at_end) begin
      reset_walk();
    end else begin
      dest_next = dest_next + 1'b1;
      if (!end_lane) begin
        lane_pos++;
      end else begin
        lane_pos = 0;
        if (!end_kern) begin
          kern_pos++;
        end else begin
          kern_pos = 0;
          if (!end_col) begin
            col_pos++;
          end else begin
            col_pos = 0;
            if (!end_row) begin
              row_pos++;
            end else begin
              row_pos = 0;
              blk_pos++;
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void compare_field(string field, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      n_errors++;
      if (n_reports < MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
      end
      n_reports++;
    end
  endfunction

  // Driver: a stalled transfer holds its payload, otherwise the next pending
  // request goes out unless an idle burst is running.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_restart <= 1'b0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_addrs.insert(expected_addrs.size(), next_address(in_restart));
        n_sent++;
        if (in_restart) n_restarts++;
        if (!quiet && gap_left == 0 && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 3);
        end
      end
      if (in_valid && in_stall) begin
        // Payload stays put until the transfer completes.
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_restarts.size() != 0) begin
        in_valid   <= 1'b1;
        in_restart <= pending_restarts.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, so that the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_wanted && !quiet && holds_done < 2) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_addrs.size() == 0) begin
          n_errors++;
          if (n_reports < MAX_REPORTS) begin
            $display("%0t ns: result with nothing expected, got dest 0x%0h source 0x%0h",
                     $time, out_dest_index, out_source_index);
          end
          n_reports++;
        end else begin
          want = expected_addrs.pop_front();
          compare_field("dest_index", 64'(want.dest_index), 64'(out_dest_index));
          compare_field("source_index", 64'(want.source_index), 64'(out_source_index));
          compare_field("zero_fill", 64'(want.zero_fill), 64'(out_zero_fill));
          compare_field("last_element", 64'(want.last_element), 64'(out_last_element));
          n_checked++;
          if (out_last_element) n_last_seen++;
          if (out_zero_fill) n_pad_seen++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, expected_addrs.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Wait until every request has been sent, every result has come back and
  // any receiver hold-off has run out.
  task automatic drain();
    @(negedge clk);
    while (pending_restarts.size() != 0 || expected_addrs.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    hold_wanted = 1'b0;
    while (hold_left != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [fzag_pkg::CFG_IDX_W-1:0] idx,
                           logic [fzag_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic set_geometry(logic [fzag_pkg::CFG_DATA_W-1:0] layout,
                              logic [fzag_pkg::CFG_DATA_W-1:0] n,
                              logic [fzag_pkg::CFG_DATA_W-1:0] c,
                              logic [fzag_pkg::CFG_DATA_W-1:0] h,
                              logic [fzag_pkg::CFG_DATA_W-1:0] w,
                              logic [fzag_pkg::CFG_DATA_W-1:0] wide);
    write_reg(fzag_pkg::REG_SOURCE_LAYOUT, layout);
    write_reg(fzag_pkg::REG_KERNEL_COUNT, n);
    write_reg(fzag_pkg::REG_CHANNEL_COUNT, c);
    write_reg(fzag_pkg::REG_KERNEL_HEIGHT, h);
    write_reg(fzag_pkg::REG_KERNEL_WIDTH, w);
    write_reg(fzag_pkg::REG_CUBE_WIDE, wide);
    n_settings++;
  endtask

  // Queues a fixed pattern of restart flags, bit 0 first.
  task automatic offer_pattern(logic [31:0] flags, int unsigned count);
    int unsigned i;
    @(negedge clk);
    for (i = 0; i < count; i++) begin
      pending_restarts.insert(pending_restarts.size(), flags[i]);
    end
  endtask

  // One random phase: a new setting, then a run of requests no longer than
  // the budget. Most settings are small enough for the walk to wrap.
  task automatic random_phase(bit tiny_only, int unsigned budget, output int unsigned count);
    int unsigned n, c, h, w, c0, walk, i;
    bit          wide, noisy, first_restart;
    if (!tiny_only && $urandom_range(0, 4) == 0) begin
      set_geometry(fzag_pkg::CFG_DATA_W'($urandom), fzag_pkg::CFG_DATA_W'($urandom),
                   fzag_pkg::CFG_DATA_W'($urandom), fzag_pkg::CFG_DATA_W'($urandom),
                   fzag_pkg::CFG_DATA_W'($urandom), fzag_pkg::CFG_DATA_W'($urandom));
      count = $urandom_range(40, 120);
    end else begin
      wide = 1'($urandom_range(0, 1));
      c0   = wide ? 32 : 16;
      n    = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
      c    = $urandom_range(1, 2 * c0);
      h    = ($urandom_range(0, 3) == 0) ? 2 : 1;
      w    = ($urandom_range(0, 3) == 0) ? 2 : 1;
      set_geometry(fzag_pkg::CFG_DATA_W'($urandom_range(0, 3)), fzag_pkg::CFG_DATA_W'(n),
                   fzag_pkg::CFG_DATA_W'(c), fzag_pkg::CFG_DATA_W'(h),
                   fzag_pkg::CFG_DATA_W'(w), fzag_pkg::CFG_DATA_W'(wide));
      walk  = ((c + c0 - 1) / c0) * h * w
              * ((n + fzag_pkg::KERNEL_BLOCK - 1) / fzag_pkg::KERNEL_BLOCK)
              * fzag_pkg::KERNEL_BLOCK * c0;
      count = (walk <= 768) ? walk + $urandom_range(0, 8) : $urandom_range(100, 300);
    end
    if (count > budget) begin
      count = budget;
    end
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                fzag_pkg::CFG_DATA_W'($urandom));
    end
    // Half the phases are clean walks; the rest carry the odd restart.
    noisy         = 1'($urandom_range(0, 1));
    first_restart = ($urandom_range(0, 3) == 0);
    @(negedge clk);
    for (i = 0; i < count; i++) begin
      pending_restarts.insert(pending_restarts.size(),
                              (i == 0 && first_restart) ||
                              (noisy && $urandom_range(0, 63) == 0));
    end
    hold_wanted = (count >= HOLD_DEPTH) && !quiet;
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned phase_items;
    random_sent  = 0;
    cur_layout   = fzag_pkg::LAYOUT_NCHW;
    cur_kernels  = fzag_pkg::COUNT_W'(1);
    cur_channels = fzag_pkg::COUNT_W'(1);
    cur_height   = fzag_pkg::SPATIAL_W'(1);
    cur_width    = fzag_pkg::SPATIAL_W'(1);
    cur_wide     = 1'b0;
    reset_walk();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: one real element, then padding, then a restart.
    offer_pattern(32'b0100, 4);
    drain();

    // Each layout on one small tensor, plus the reserved code.
    set_geometry(fzag_pkg::CFG_DATA_W'(fzag_pkg::LAYOUT_NCHW), 13'd3, 13'd5, 13'd2, 13'd2,
                 13'd0);
    offer_pattern(32'b0001, 4);
    drain();
    write_reg(fzag_pkg::REG_SOURCE_LAYOUT, fzag_pkg::CFG_DATA_W'(fzag_pkg::LAYOUT_HWCN));
    offer_pattern(32'b0, 2);
    drain();
    write_reg(fzag_pkg::REG_SOURCE_LAYOUT, fzag_pkg::CFG_DATA_W'(fzag_pkg::LAYOUT_NHWC));
    offer_pattern(32'b0, 2);
    drain();
    write_reg(fzag_pkg::REG_SOURCE_LAYOUT, fzag_pkg::CFG_DATA_W'(LAYOUT_RESERVED));
    offer_pattern(32'b0, 2);
    drain();

    // Every size field at its top value saturates; the wide lane block too.
    set_geometry(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    offer_pattern(32'b010, 3);
    drain();

    // Zero sizes count as one.
    set_geometry(fzag_pkg::CFG_DATA_W'(fzag_pkg::LAYOUT_NHWC), 13'd0, 13'd0, 13'd0, 13'd0,
                 13'd0);
    offer_pattern(32'b0, 3);
    drain();

    // Writes to unused indexes in the middle of a walk restart it.
    set_geometry(fzag_pkg::CFG_DATA_W'(fzag_pkg::LAYOUT_NCHW), 13'd2, 13'd20, 13'd1, 13'd1,
                 13'd1);
    offer_pattern(32'b0, 3);
    drain();
    write_reg(REG_SPARE_LO, 13'h1555);
    offer_pattern(32'b0, 2);
    drain();
    write_reg(REG_SPARE_HI, 13'h0AAA);
    offer_pattern(32'b0, 1);
    drain();

    // Random phases with idling on both sides.
    while (random_sent + QUIET_ITEMS < RANDOM_ITEMS) begin
      random_phase(1'b0, RANDOM_ITEMS - QUIET_ITEMS - random_sent, phase_items);
      random_sent += phase_items;
      drain();
    end

    // Closing phase at full rate, no idling on either side.
    quiet = 1'b1;
    random_phase(1'b1, RANDOM_ITEMS - random_sent, phase_items);
    random_sent += phase_items;
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests over %0d settings, %0d of them random, %0d restarts.",
             n_sent, n_settings, random_sent, n_restarts);
    $display("Checked %0d results: %0d walk ends, %0d padded, %0d long hold-offs.",
             n_checked, n_last_seen, n_pad_seen, holds_done);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/fzag_pkg.sv
rtl/core/fzag_cfg_strides.sv
rtl/core/fzag_walk.sv
rtl/core/fzag_out_buf.sv
rtl/core/fractal_z_layout_address_gen_unit.sv
verif/fractal_z_layout_address_gen_unit_tb.sv
